// ===== rtl/ipu_pkg.sv =====
// Shared constants and types for the integer pixel upscaler.
package ipu_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_SCALE_DEF = 60;

    localparam int SCALE_W    = 6;
    localparam int CFG_DATA_W = 13;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int PAD_W      = 2;

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    localparam logic MODE_PIXEL  = 1'b0;
    localparam logic MODE_REPLAY = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [SCALE_W-1:0] scale;
        logic [PAD_W-1:0]   pad;
        logic               eol;
        logic               pending;
    } t_job;

endpackage

// ===== rtl/ipu_line_mem.sv =====
// Line store: one write port and one read port with registered read data.
module ipu_line_mem #(
    parameter int DEPTH = ipu_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [ipu_pkg::PIX_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output logic [ipu_pkg::PIX_W-1:0] o_rd_data
);

    logic [ipu_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [ipu_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ipu_emitter.sv =====
// Output sequencer that repeats a pixel and appends padding beats.
module ipu_emitter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  ipu_pkg::t_job              i_job,
    output logic                       o_job_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ipu_pkg::CHAN_W-1:0] o_blue_out,
    output logic [ipu_pkg::CHAN_W-1:0] o_green_out,
    output logic [ipu_pkg::CHAN_W-1:0] o_red_out,
    output logic                       o_is_padding,
    output logic                       o_line_end,
    output logic                       o_replay_pending,
    output logic                       o_last
);

    logic                        r_valid;
    logic [ipu_pkg::PIX_W-1:0]   r_pixel;
    logic [ipu_pkg::SCALE_W-1:0] r_copies_left;
    logic [ipu_pkg::PAD_W-1:0]   r_pad_left;
    logic                        r_eol;
    logic                        r_pending;
    logic                        r_is_pad;
    logic                        r_last;
    logic                        job_take;

    assign o_job_ready = !r_valid || (i_ready && r_last);
    assign job_take    = i_job_valid && o_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (job_take) begin
            r_valid       <= 1'b1;
            r_pixel       <= i_job.pixel;
            r_copies_left <= i_job.scale - ipu_pkg::SCALE_W'(1);
            r_pad_left    <= i_job.pad;
            r_eol         <= i_job.eol;
            r_pending     <= i_job.pending;
            r_is_pad      <= 1'b0;
            r_last        <= (i_job.scale == ipu_pkg::SCALE_W'(1)) &&
                             (i_job.pad == '0);
        end else if (r_valid && i_ready) begin
            if (r_last) begin
                r_valid <= 1'b0;
            end else if (r_copies_left != '0) begin
                r_copies_left <= r_copies_left - ipu_pkg::SCALE_W'(1);
                r_is_pad      <= 1'b0;
                r_last        <= (r_copies_left == ipu_pkg::SCALE_W'(1)) &&
                                 (r_pad_left == '0);
            end else begin
                r_pad_left <= r_pad_left - ipu_pkg::PAD_W'(1);
                r_is_pad   <= 1'b1;
                r_last     <= (r_pad_left == ipu_pkg::PAD_W'(1));
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_blue_out       = r_is_pad ? '0 : r_pixel[ipu_pkg::CHAN_W-1:0];
    assign o_green_out      = r_is_pad ? '0 : r_pixel[2*ipu_pkg::CHAN_W-1:ipu_pkg::CHAN_W];
    assign o_red_out        = r_is_pad ? '0 : r_pixel[3*ipu_pkg::CHAN_W-1:2*ipu_pkg::CHAN_W];
    assign o_is_padding     = r_is_pad;
    assign o_line_end       = r_last && r_eol;
    assign o_replay_pending = r_pending;
    assign o_last           = r_last;

endmodule

// ===== rtl/integer_pixel_upscaler.sv =====
// Integer nearest-neighbor upscaler top level with line store and control.
//
// Each accepted source pixel (mode 0) is stored in the line store and sent out
// scale times; after the last pixel of a line, (width*scale) mod 4 zero padding
// beats follow. The line is then replayed scale-1 more times, one replay
// request (mode 1) per stored pixel. Items that do not fit the current phase
// are accepted and dropped without a result. The output port moves one beat
// per cycle while i_ready is high, and an item is scale plus padding beats long,
// between 1 and 63; the next item is taken while the last beat of the previous
// one is delivered. An accepted item is held in the r_s1 registers, where a
// replay also reads the line store, and is then loaded into the emitter.
module integer_pixel_upscaler #(
    parameter int MAX_WIDTH = ipu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = ipu_pkg::MAX_SCALE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [ipu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [ipu_pkg::CHAN_W-1:0]     i_blue_in,
    input  logic [ipu_pkg::CHAN_W-1:0]     i_green_in,
    input  logic [ipu_pkg::CHAN_W-1:0]     i_red_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ipu_pkg::CHAN_W-1:0]     o_blue_out,
    output logic [ipu_pkg::CHAN_W-1:0]     o_green_out,
    output logic [ipu_pkg::CHAN_W-1:0]     o_red_out,
    output logic                           o_is_padding,
    output logic                           o_line_end,
    output logic                           o_replay_pending,
    output logic                           o_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > ipu_pkg::CFG_DATA_W) ? CW + 1 : ipu_pkg::CFG_DATA_W;
    localparam int SW = ipu_pkg::SCALE_W;

    logic [SW-1:0]                   r_scale_factor;
    logic [ipu_pkg::CFG_DATA_W-1:0]  r_line_width;
    logic [CW-1:0]                   r_write_col;
    logic [CW-1:0]                   r_replay_col;
    logic [SW-1:0]                   r_replays_left;

    logic                            r_s1_valid;
    logic                            r_s1_from_mem;
    logic [ipu_pkg::PIX_W-1:0]       r_s1_pixel;
    logic [SW-1:0]                   r_s1_scale;
    logic [ipu_pkg::PAD_W-1:0]       r_s1_pad;
    logic                            r_s1_eol;
    logic                            r_s1_pending;

    logic [SW-1:0]                   eff_scale;
    logic [WW-1:0]                   eff_width;
    logic [WW-1:0]                   width_ext;
    logic                            accept;
    logic                            is_pix;
    logic                            act;
    logic [CW-1:0]                   col;
    logic [WW-1:0]                   col_next;
    logic                            eol;
    logic [ipu_pkg::PAD_W-1:0]       pad;
    logic [ipu_pkg::PAD_W+1:0]       pad_prod;
    logic                            pending;
    logic [ipu_pkg::PIX_W-1:0]       in_pixel;
    logic [ipu_pkg::PIX_W-1:0]       mem_rd_data;
    logic                            job_ready;
    logic                            s1_take;
    ipu_pkg::t_job                   job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_factor <= SW'(1);
            r_line_width   <= ipu_pkg::CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ipu_pkg::REG_SCALE: r_scale_factor <= i_cfg_data[SW-1:0];
                ipu_pkg::REG_WIDTH: r_line_width   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign width_ext = WW'(r_line_width);

    always_comb begin
        if (r_scale_factor == '0) begin
            eff_scale = SW'(1);
        end else if (r_scale_factor > SW'(MAX_SCALE)) begin
            eff_scale = SW'(MAX_SCALE);
        end else begin
            eff_scale = r_scale_factor;
        end
        if (width_ext == '0) begin
            eff_width = WW'(1);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
    end

    assign s1_take  = r_s1_valid && job_ready;
    assign o_ready  = !r_s1_valid || job_ready;
    assign accept   = i_valid && o_ready;
    assign is_pix   = (i_mode == ipu_pkg::MODE_PIXEL);
    assign act      = accept && (is_pix ? (r_replays_left == '0) : (r_replays_left != '0));
    assign col      = is_pix ? r_write_col : r_replay_col;
    assign col_next = WW'(col) + WW'(1);
    assign eol      = (col_next >= eff_width);
    assign pad_prod = eff_width[1:0] * eff_scale[1:0];
    assign pad      = pad_prod[ipu_pkg::PAD_W-1:0];
    assign in_pixel = {i_red_in, i_green_in, i_blue_in};

    always_comb begin
        if (is_pix) begin
            pending = eol && (eff_scale != SW'(1));
        end else begin
            pending = !eol || (r_replays_left != SW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_col    <= '0;
            r_replay_col   <= '0;
            r_replays_left <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (act) begin
                if (is_pix) begin
                    if (eol) begin
                        r_write_col    <= '0;
                        r_replay_col   <= '0;
                        r_replays_left <= eff_scale - SW'(1);
                    end else begin
                        r_write_col <= col_next[CW-1:0];
                    end
                end else begin
                    if (eol) begin
                        r_replay_col   <= '0;
                        r_replays_left <= r_replays_left - SW'(1);
                    end else begin
                        r_replay_col <= col_next[CW-1:0];
                    end
                end
                r_s1_valid    <= 1'b1;
                r_s1_from_mem <= !is_pix;
                r_s1_pixel    <= in_pixel;
                r_s1_scale    <= eff_scale;
                r_s1_pad      <= eol ? pad : '0;
                r_s1_eol      <= eol;
                r_s1_pending  <= pending;
            end else if (s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    ipu_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (act && is_pix),
        .i_wr_addr (r_write_col),
        .i_wr_data (in_pixel),
        .i_rd_en   (act && !is_pix),
        .i_rd_addr (r_replay_col),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        job.pixel   = r_s1_from_mem ? mem_rd_data : r_s1_pixel;
        job.scale   = r_s1_scale;
        job.pad     = r_s1_pad;
        job.eol     = r_s1_eol;
        job.pending = r_s1_pending;
    end

    ipu_emitter u_emitter (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (r_s1_valid),
        .i_job            (job),
        .o_job_ready      (job_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_blue_out       (o_blue_out),
        .o_green_out      (o_green_out),
        .o_red_out        (o_red_out),
        .o_is_padding     (o_is_padding),
        .o_line_end       (o_line_end),
        .o_replay_pending (o_replay_pending),
        .o_last           (o_last)
    );

endmodule
